@@ rtl/bpt_pkg.sv @@
// Shared types and constants for the barometric pressure/temperature compensation block.
// No dependencies.
package bpt_pkg;

  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned RAW_W    = 24;
  localparam int unsigned TEMP_W   = 16;
  localparam int unsigned PRES_W   = 22;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS_COEFF    = 3'd0,
    REG_OFFSET_COEFF  = 3'd1,
    REG_SENS_TEMPCO   = 3'd2,
    REG_OFFSET_TEMPCO = 3'd3,
    REG_REF_TEMP_WORD = 3'd4,
    REG_TEMP_COEFF    = 3'd5
  } cfg_reg_t;

  typedef logic [RAW_W-1:0]         raw_t;
  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic signed [PRES_W-1:0] pres_t;

  localparam temp_t TEMP_BASE = 16'sd2000;

  localparam logic signed [35:0] OFF_MIN  = -36'sd8589672450;
  localparam logic signed [35:0] OFF_MAX  =  36'sd12884705280;
  localparam logic signed [34:0] SENS_MIN = -35'sd4294836225;
  localparam logic signed [34:0] SENS_MAX =  35'sd6442352640;
  localparam logic signed [23:0] PRES_MIN = -24'sd2097152;
  localparam logic signed [23:0] PRES_MAX =  24'sd2097151;

endpackage

@@ rtl/bpt_if.sv @@
// Valid/ready channel interfaces for raw sample requests and compensated results.
// Depends on bpt_pkg.
interface bpt_sample_if;
  logic          valid;
  logic          ready;
  bpt_pkg::raw_t raw_pressure;
  bpt_pkg::raw_t raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface bpt_result_if;
  logic           valid;
  logic           ready;
  bpt_pkg::temp_t temperature_centideg;
  bpt_pkg::pres_t pressure_pa;

  modport source (output valid, output temperature_centideg, output pressure_pa, input ready);
  modport sink   (input valid, input temperature_centideg, input pressure_pa, output ready);
endinterface

@@ rtl/baro_pressure_temp_compensation.sv @@
// Throughput: one request per cycle; each stage holds on stall and bubbles collapse.
// Pressure product is split into a 25x17 and a 24x17 partial product over two stages.
// Reset (rst, synchronous, active high) clears stage valids and calibration words.
// Depends on bpt_pkg and bpt_if.
module baro_pressure_temp_compensation (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [bpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpt_pkg::CFG_W-1:0]  cfg_data,
  bpt_sample_if.sink                 sample,
  bpt_result_if.source               result
);

  localparam int unsigned NS = 9;

  logic [15:0] c1, c2, c3, c4, c5, c6;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0; c2 <= '0; c3 <= '0; c4 <= '0; c5 <= '0; c6 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bpt_pkg::REG_SENS_COEFF:    c1 <= cfg_data;
        bpt_pkg::REG_OFFSET_COEFF:  c2 <= cfg_data;
        bpt_pkg::REG_SENS_TEMPCO:   c3 <= cfg_data;
        bpt_pkg::REG_OFFSET_TEMPCO: c4 <= cfg_data;
        bpt_pkg::REG_REF_TEMP_WORD: c5 <= cfg_data;
        bpt_pkg::REG_TEMP_COEFF:    c6 <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage valids and per-stage enables
  logic [NS-1:0] vld;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = result.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign sample.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= sample.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage payload
  logic [23:0]        d1_0, d1_1, d1_2, d1_3;
  logic signed [24:0] dt_0;
  logic signed [41:0] m6_1, m4_1, m3_1;
  logic signed [15:0] temp_2, temp_3, temp_4, temp_5, temp_6, temp_7, temp_8;
  logic signed [35:0] off_raw_2;
  logic signed [34:0] sens_raw_2;
  logic signed [34:0] off_3, off_4, off_5, off_6;
  logic signed [33:0] sens_3;
  logic signed [41:0] pp_hi_4;
  logic [40:0]        pp_lo_4;
  logic signed [58:0] prod_5;
  logic signed [37:0] q_6;
  logic signed [38:0] diff_7;
  logic signed [21:0] p_8;

  // combinational helpers
  logic signed [41:0] m6b, m4b, m3b;
  logic signed [34:0] q4;
  logic signed [33:0] q3;
  logic signed [16:0] sens_hi;
  logic [16:0]        sens_lo;
  logic signed [58:0] pb;
  logic signed [38:0] db;
  logic signed [23:0] pq;

  always_comb begin
    m6b = m6_1 + $signed({16'b0, {26{m6_1[41]}}});
    m4b = m4_1 + $signed({35'b0, {7{m4_1[41]}}});
    m3b = m3_1 + $signed({34'b0, {8{m3_1[41]}}});
    q4  = m4b[41:7];
    q3  = m3b[41:8];
    sens_hi = sens_3[33:17];
    sens_lo = sens_3[16:0];
    pb  = prod_5 + $signed({38'b0, {21{prod_5[58]}}});
    db  = diff_7 + $signed({24'b0, {15{diff_7[38]}}});
    pq  = db[38:15];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d1_0 <= sample.raw_pressure;
      dt_0 <= $signed({1'b0, sample.raw_temperature}) - $signed({1'b0, c5, 8'b0});
    end
    if (en[1]) begin
      d1_1 <= d1_0;
      m6_1 <= dt_0 * $signed({1'b0, c6});
      m4_1 <= dt_0 * $signed({1'b0, c4});
      m3_1 <= dt_0 * $signed({1'b0, c3});
    end
    if (en[2]) begin
      d1_2       <= d1_1;
      temp_2     <= m6b[41:26] + bpt_pkg::TEMP_BASE;
      off_raw_2  <= $signed({4'b0, c2, 16'b0}) + 36'(q4);
      sens_raw_2 <= $signed({4'b0, c1, 15'b0}) + 35'(q3);
    end
    if (en[3]) begin
      d1_3   <= d1_2;
      temp_3 <= temp_2;
      if (off_raw_2 < bpt_pkg::OFF_MIN) begin
        off_3 <= bpt_pkg::OFF_MIN[34:0];
      end else if (off_raw_2 > bpt_pkg::OFF_MAX) begin
        off_3 <= bpt_pkg::OFF_MAX[34:0];
      end else begin
        off_3 <= off_raw_2[34:0];
      end
      if (sens_raw_2 < bpt_pkg::SENS_MIN) begin
        sens_3 <= bpt_pkg::SENS_MIN[33:0];
      end else if (sens_raw_2 > bpt_pkg::SENS_MAX) begin
        sens_3 <= bpt_pkg::SENS_MAX[33:0];
      end else begin
        sens_3 <= sens_raw_2[33:0];
      end
    end
    if (en[4]) begin
      temp_4  <= temp_3;
      off_4   <= off_3;
      pp_hi_4 <= $signed({1'b0, d1_3}) * sens_hi;
      pp_lo_4 <= d1_3 * sens_lo;
    end
    if (en[5]) begin
      temp_5 <= temp_4;
      off_5  <= off_4;
      prod_5 <= $signed({pp_hi_4, 17'b0}) + $signed({18'b0, pp_lo_4});
    end
    if (en[6]) begin
      temp_6 <= temp_5;
      off_6  <= off_5;
      q_6    <= pb[58:21];
    end
    if (en[7]) begin
      temp_7 <= temp_6;
      diff_7 <= 39'(q_6) - 39'(off_6);
    end
    if (en[8]) begin
      temp_8 <= temp_7;
      if (pq < bpt_pkg::PRES_MIN) begin
        p_8 <= bpt_pkg::PRES_MIN[21:0];
      end else if (pq > bpt_pkg::PRES_MAX) begin
        p_8 <= bpt_pkg::PRES_MAX[21:0];
      end else begin
        p_8 <= pq[21:0];
      end
    end
  end

  assign result.valid                = vld[NS-1];
  assign result.temperature_centideg = temp_8;
  assign result.pressure_pa          = p_8;

endmodule

@@ rtl/bpt_checker.sv @@
// Port-level checks for the compensation block, attached by bind.
// Depends on the top level baro_pressure_temp_compensation.
module bpt_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  res_valid,
  input logic                  res_ready,
  input logic signed [15:0]    res_temp,
  input logic signed [21:0]    res_pres
);

  // a held result stays up
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // compensated temperature stays in its physical span
  a_temp: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_temp >= -16'sd14384) && (res_temp <= 16'sd18384))
    else $error("temperature out of range");

  // payload frozen across a stall
  a_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_temp) && $stable(res_pres))
    else $error("result payload changed while stalled");

endmodule

bind baro_pressure_temp_compensation bpt_checker u_bpt_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_temp  (result.temperature_centideg),
  .res_pres  (result.pressure_pa)
);

@@ tb/tb_baro_pressure_temp_compensation.sv @@
`timescale 1ns / 100ps
// Self-checking bench for baro_pressure_temp_compensation: typed-in and predicted readings.
// Depends on bpt_pkg, bpt_if and the block itself.
module tb_baro_pressure_temp_compensation;

  localparam int NUM_CAL     = bpt_pkg::REG_TEMP_COEFF + 1;
  localparam int NUM_IDX     = 2 ** bpt_pkg::CFG_IDX_W;
  localparam longint DT_LO   = -64'sd16776960;
  localparam longint DT_HI   = 64'sd16777216;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 241;
  localparam int NUM_VECTORS = 19;

  typedef struct {
    bpt_pkg::temp_t temp_cd;
    bpt_pkg::pres_t pres;
  } reading_t;

  typedef struct {
    int unsigned    cal_set;
    bpt_pkg::raw_t  prs;
    bpt_pkg::raw_t  tmp;
    bit             typed;
    bpt_pkg::temp_t t_exp;
    bpt_pkg::pres_t p_exp;
  } vector_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we;
  logic [bpt_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bpt_pkg::CFG_W-1:0]     cfg_data;

  bpt_sample_if sample_ch ();
  bpt_result_if result_ch ();

  baro_pressure_temp_compensation dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  always #5 clk = ~clk;

  logic [bpt_pkg::CFG_W-1:0] cal [NUM_CAL];
  logic [bpt_pkg::CFG_W-1:0] next_cal [NUM_CAL];
  reading_t         expected_readings [$];
  reading_t         head;
  bit               quiet = 1'b0;
  bit               stall_long = 1'b0;
  int unsigned      errors = 0;
  int unsigned      accepted = 0;
  int unsigned      checked = 0;
  int unsigned      cal_loads = 0;

  logic [bpt_pkg::CFG_W-1:0] cal_sets [4][NUM_CAL] = '{
    '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
    '{16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF}
  };

  // reset rows: all words zero, so every request reads 20.00 C and 0 Pa
  vector_t vectors [NUM_VECTORS] = '{
    '{0, 24'h000000, 24'h000000, 1'b1, 16'sd2000, 22'sd0},
    '{0, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 16'sd2000, 22'sd0},
    '{0, 24'hAAAAAA, 24'h555555, 1'b1, 16'sd2000, 22'sd0},
    '{0, 24'h555555, 24'hAAAAAA, 1'b1, 16'sd2000, 22'sd0},
    '{1, 24'h000000, 24'h000000, 1'b0, 16'sd0, 22'sd0},
    '{1, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 16'sd0, 22'sd0},
    '{1, 24'hFFFFFF, 24'h000000, 1'b0, 16'sd0, 22'sd0},
    '{1, 24'h000000, 24'hFFFFFF, 1'b0, 16'sd0, 22'sd0},
    '{1, 24'd9085466, 24'd8569150, 1'b0, 16'sd0, 22'sd0},
    '{1, 24'd9085466, 24'h82B800, 1'b0, 16'sd0, 22'sd0},
    '{2, 24'h000000, 24'h000000, 1'b0, 16'sd0, 22'sd0},
    '{2, 24'hFFFFFF, 24'h000000, 1'b0, 16'sd0, 22'sd0},
    '{2, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 16'sd0, 22'sd0},
    '{2, 24'h000000, 24'hFFFFFF, 1'b0, 16'sd0, 22'sd0},
    '{2, 24'h800000, 24'hFFFF00, 1'b0, 16'sd0, 22'sd0},
    '{3, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 16'sd0, 22'sd0},
    '{3, 24'h000000, 24'hFFFFFF, 1'b0, 16'sd0, 22'sd0},
    '{3, 24'hFFFFFF, 24'h000000, 1'b0, 16'sd0, 22'sd0},
    '{3, 24'h123456, 24'h800000, 1'b0, 16'sd0, 22'sd0}
  };

  function automatic longint shr_trunc(longint v, int sh);
    if (v < 0)
      return -((-v) >>> sh);
    return v >>> sh;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo)
      return lo;
    if (v > hi)
      return hi;
    return v;
  endfunction

  function automatic reading_t compensate(bpt_pkg::raw_t prs, bpt_pkg::raw_t tmp);
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, tc, off, sens, pa;
    reading_t r;
    d1 = prs;
    d2 = tmp;
    c1 = cal[bpt_pkg::REG_SENS_COEFF];
    c2 = cal[bpt_pkg::REG_OFFSET_COEFF];
    c3 = cal[bpt_pkg::REG_SENS_TEMPCO];
    c4 = cal[bpt_pkg::REG_OFFSET_TEMPCO];
    c5 = cal[bpt_pkg::REG_REF_TEMP_WORD];
    c6 = cal[bpt_pkg::REG_TEMP_COEFF];
    dt   = clip(d2 - c5 * 256, DT_LO, DT_HI);
    tc   = longint'(bpt_pkg::TEMP_BASE) + shr_trunc(dt * c6, 26);
    off  = clip(c2 * 65536 + shr_trunc(c4 * dt, 7),
                longint'(bpt_pkg::OFF_MIN), longint'(bpt_pkg::OFF_MAX));
    sens = clip(c1 * 32768 + shr_trunc(c3 * dt, 8),
                longint'(bpt_pkg::SENS_MIN), longint'(bpt_pkg::SENS_MAX));
    pa   = shr_trunc(shr_trunc(d1 * sens, 21) - off, 15);
    r.temp_cd = bpt_pkg::temp_t'(clip(tc, -64'sd32768, 64'sd32767));
    r.pres    = bpt_pkg::pres_t'(clip(pa, longint'(bpt_pkg::PRES_MIN),
                                      longint'(bpt_pkg::PRES_MAX)));
    return r;
  endfunction

  task automatic load_cal();
    for (int i = bpt_pkg::REG_SENS_COEFF; i < NUM_CAL; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[bpt_pkg::CFG_IDX_W-1:0];
      cfg_data  <= next_cal[i];
      @(posedge clk);
      cal[i] = next_cal[i];
    end
    // indexes past the last word must be dropped
    for (int i = NUM_CAL; i < NUM_IDX; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[bpt_pkg::CFG_IDX_W-1:0];
      cfg_data  <= bpt_pkg::CFG_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cal_loads++;
  endtask

  task automatic drain();
    sample_ch.valid <= 1'b0;
    while (expected_readings.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic offer(bpt_pkg::raw_t prs, bpt_pkg::raw_t tmp, bit typed,
                       bpt_pkg::temp_t t_exp, bpt_pkg::pres_t p_exp);
    reading_t want;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    sample_ch.valid           <= 1'b1;
    sample_ch.raw_pressure    <= prs;
    sample_ch.raw_temperature <= tmp;
    @(posedge clk);
    while (!sample_ch.ready)
      @(posedge clk);
    if (typed) begin
      want.temp_cd = t_exp;
      want.pres    = p_exp;
    end else begin
      want = compensate(prs, tmp);
    end
    expected_readings.push_back(want);
    accepted++;
  endtask

  // result side: random stalls, one long hold when asked
  initial begin
    bit rdy;
    int cnt;
    forever begin
      if (stall_long) begin
        rdy = 1'b0;
        cnt = 100;
        stall_long = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        rdy = 1'b0;
        cnt = $urandom_range(1, 10);
      end else begin
        rdy = 1'b1;
        cnt = $urandom_range(1, 20);
      end
      result_ch.ready <= rdy;
      repeat (cnt) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_readings.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got temp %0d pres %0d", $time,
                 result_ch.temperature_centideg, result_ch.pressure_pa);
      end else begin
        head = expected_readings.pop_front();
        checked++;
        if (result_ch.temperature_centideg !== head.temp_cd) begin
          errors++;
          $display("%0t: temperature_centideg mismatch, expected %0d, got %0d", $time,
                   head.temp_cd, result_ch.temperature_centideg);
        end
        if (result_ch.pressure_pa !== head.pres) begin
          errors++;
          $display("%0t: pressure_pa mismatch, expected %0d, got %0d", $time,
                   head.pres, result_ch.pressure_pa);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding", expected_readings.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int unsigned set_now;
    bpt_pkg::raw_t prs, tmp;
    int v;
    sample_ch.valid           <= 1'b0;
    sample_ch.raw_pressure    <= '0;
    sample_ch.raw_temperature <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= bpt_pkg::REG_SENS_COEFF;
    cfg_data  <= '0;
    foreach (cal[i])
      cal[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_now = 0;
    foreach (vectors[k]) begin
      if (vectors[k].cal_set != set_now) begin
        drain();
        set_now = vectors[k].cal_set;
        next_cal = cal_sets[set_now];
        load_cal();
      end
      offer(vectors[k].prs, vectors[k].tmp, vectors[k].typed, vectors[k].t_exp,
            vectors[k].p_exp);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      foreach (next_cal[i]) begin
        case ($urandom_range(0, 5))
          0: next_cal[i] = '0;
          1: next_cal[i] = '1;
          2, 3: next_cal[i] = cal_sets[1][i] + bpt_pkg::CFG_W'($urandom_range(0, 4000))
                              - 16'd2000;
          default: next_cal[i] = bpt_pkg::CFG_W'($urandom);
        endcase
        if (ph == 0)
          next_cal[i] = '1;
        else if (ph == 1)
          next_cal[i] = '0;
      end
      load_cal();
      if (ph == RAND_PHASES - 1)
        quiet = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == 16)
          stall_long = 1'b1;
        if (ph == 4 && n == PHASE_ITEMS / 2)
          drain();
        case ($urandom_range(0, 7))
          0: prs = '0;
          1: prs = '1;
          2, 3: prs = bpt_pkg::raw_t'($urandom_range(6000000, 11000000));
          default: prs = bpt_pkg::raw_t'($urandom);
        endcase
        case ($urandom_range(0, 7))
          0: tmp = '0;
          1: tmp = '1;
          2, 3, 4: begin
            v = int'(cal[bpt_pkg::REG_REF_TEMP_WORD]) * 256
                + int'($urandom_range(0, 131072)) - 65536;
            if (v < 0)
              v = 0;
            if (v > 24'hFFFFFF)
              v = 24'hFFFFFF;
            tmp = bpt_pkg::raw_t'(v);
          end
          default: tmp = bpt_pkg::raw_t'($urandom);
        endcase
        offer(prs, tmp, 1'b0, '0, '0);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Covered %0d requests over %0d calibration loads, %0d results checked,",
             accepted, cal_loads, checked);
    $display("with a long result stall, a full drain mid-phase and extreme words.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
